@@ rtl/sal_pkg.sv @@
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants for the static array list engine.
// ----------------------------------------------------------------------------
package sal_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int MAX_RESULTS = 16;
	localparam logic [9:0] GRADE_MAX = 10'd1000;
	localparam logic [4:0] LIMIT_RESET = 5'd16;

	localparam logic [2:0] K_APPEND = 3'd0;
	localparam logic [2:0] K_FIND = 3'd1;
	localparam logic [2:0] K_READ = 3'd2;
	localparam logic [2:0] K_DELETE = 3'd3;
	localparam logic [2:0] K_INSERT = 3'd4;
	localparam logic [2:0] K_SORT = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_MISS = 2'd3;

	typedef enum logic [2:0] {
		DOP_NONE,
		DOP_WRITE_IN,
		DOP_COPY,
		DOP_SWAP
	} dop_t;

	typedef struct packed {
		dop_t op;
		logic [7:0] addr_a;
		logic [7:0] addr_b;
	} dp_cmd_t;

endpackage

@@ rtl/sal_datapath.sv @@
// ----------------------------------------------------------------------------
// sal_datapath
// Entry storage with two registered read ports, one copy or swap per cycle.
// ----------------------------------------------------------------------------
module sal_datapath #(
	parameter int CAPACITY = sal_pkg::CAPACITY_DEF,
	parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic            clk,
	input  sal_pkg::dp_cmd_t cmd,
	input  logic [AW-1:0]   rd_a,
	input  logic [AW-1:0]   rd_b,
	input  logic [31:0]     in_key,
	input  logic [9:0]      in_grade,
	output logic [31:0]     key_a,
	output logic [9:0]      grade_a,
	output logic [31:0]     key_b,
	output logic [9:0]      grade_b
);
	import sal_pkg::*;

	logic [31:0] key_mem [CAPACITY];
	logic [9:0]  grade_mem [CAPACITY];
	logic [AW-1:0] wa, wb;

	assign wa = cmd.addr_a[AW-1:0];
	assign wb = cmd.addr_b[AW-1:0];

	always_ff @(posedge clk) begin
		case (cmd.op)
			DOP_WRITE_IN: begin
				key_mem[wa] <= in_key;
				grade_mem[wa] <= in_grade;
			end
			DOP_COPY: begin
				key_mem[wa] <= key_b;
				grade_mem[wa] <= grade_b;
			end
			DOP_SWAP: begin
				key_mem[wa] <= key_b;
				grade_mem[wa] <= grade_b;
				key_mem[wb] <= key_a;
				grade_mem[wb] <= grade_a;
			end
			default: begin
			end
		endcase
		key_a <= key_mem[rd_a];
		grade_a <= grade_mem[rd_a];
		key_b <= key_mem[rd_b];
		grade_b <= grade_mem[rd_b];
	end

endmodule

@@ rtl/sal_control.sv @@
// ----------------------------------------------------------------------------
// sal_control
// Operation sequencer: decodes a command, walks the store, emits results.
// ----------------------------------------------------------------------------
module sal_control #(
	parameter int CAPACITY = sal_pkg::CAPACITY_DEF,
	parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [2:0]       kind,
	input  logic [31:0]      key,
	input  logic [9:0]       grade,
	input  logic [3:0]       position,
	input  logic [4:0]       limit,
	output sal_pkg::dp_cmd_t cmd,
	output logic [AW-1:0]    rd_a,
	output logic [AW-1:0]    rd_b,
	output logic [31:0]      in_key,
	output logic [9:0]       in_grade,
	input  logic [31:0]      key_a,
	input  logic [9:0]       grade_a,
	input  logic [31:0]      key_b,
	input  logic [9:0]       grade_b,
	output logic             result_valid,
	output logic [1:0]       status,
	output logic [3:0]       entry_index,
	output logic [31:0]      entry_key,
	output logic [9:0]       entry_grade,
	output logic             last
);
	import sal_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FIND, S_READ, S_DEL, S_INS,
		S_SORT_RD, S_SORT_CMP, S_EMIT_RD, S_EMIT
	} state_t;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] NMAX = (CAPACITY > MAX_RESULTS) ? CW'(MAX_RESULTS) : CAP_C;

	state_t state_q;
	logic [2:0] kind_q;
	logic [3:0] pos_q;
	logic [CW-1:0] count_q, i_q, j_q, n_q;
	logic [CW-1:0] lim_w, pos_w;
	logic pos_oob;
	logic wait_q;

	assign busy = (state_q != S_IDLE);
	assign lim_w = (32'(limit) > 32'(CAPACITY)) ? CAP_C : CW'(limit);
	assign pos_w = CW'(pos_q);
	assign pos_oob = (32'(pos_q) >= 32'(count_q));

	always_comb begin
		rd_a = i_q[AW-1:0];
		rd_b = j_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			result_valid <= 1'b0;
			cmd <= '{DOP_NONE, 8'd0, 8'd0};
			wait_q <= 1'b0;
			kind_q <= '0;
			pos_q <= '0;
			i_q <= '0;
			j_q <= '0;
			n_q <= '0;
			in_key <= '0;
			in_grade <= '0;
			status <= '0;
			entry_index <= '0;
			entry_key <= '0;
			entry_grade <= '0;
			last <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			cmd.op <= DOP_NONE;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q <= kind;
						pos_q <= position;
						in_key <= key;
						in_grade <= (grade > GRADE_MAX) ? GRADE_MAX : grade;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					status <= ST_OK;
					entry_index <= '0;
					entry_key <= '0;
					entry_grade <= '0;
					last <= 1'b1;
					wait_q <= 1'b1;
					i_q <= '0;
					j_q <= '0;
					state_q <= S_IDLE;
					if (kind_q == K_APPEND) begin
						if (count_q >= lim_w || limit == 5'd0) begin
							status <= ST_FULL;
						end else begin
							cmd <= '{DOP_WRITE_IN, 8'(count_q), 8'd0};
							entry_index <= count_q[3:0];
							entry_key <= in_key;
							entry_grade <= in_grade;
							count_q <= count_q + 1'b1;
						end
						result_valid <= 1'b1;
					end else if (kind_q > K_SORT) begin
						status <= ST_MISS;
						result_valid <= 1'b1;
					end else if (count_q == '0) begin
						status <= ST_EMPTY;
						result_valid <= 1'b1;
					end else if (kind_q == K_FIND) begin
						state_q <= S_FIND;
					end else if (kind_q == K_SORT) begin
						j_q <= '0;
						state_q <= S_SORT_RD;
					end else if (kind_q == K_INSERT && count_q == CAP_C) begin
						status <= ST_FULL;
						result_valid <= 1'b1;
					end else if (pos_oob) begin
						status <= ST_MISS;
						result_valid <= 1'b1;
					end else if (kind_q == K_INSERT) begin
						i_q <= count_q;
						j_q <= count_q - 1'b1;
						state_q <= S_INS;
					end else begin
						i_q <= pos_w;
						j_q <= pos_w + 1'b1;
						state_q <= S_READ;
					end
				end
				S_FIND: begin
					if (wait_q) begin
						wait_q <= 1'b0;
						i_q <= i_q + 1'b1;
					end else if (key_a == in_key) begin
						status <= ST_OK;
						entry_index <= 4'(i_q - 1'b1);
						entry_key <= key_a;
						entry_grade <= grade_a;
						result_valid <= 1'b1;
						state_q <= S_IDLE;
					end else if (i_q == count_q) begin
						status <= ST_MISS;
						result_valid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_READ: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						entry_index <= pos_q;
						entry_key <= key_a;
						entry_grade <= grade_a;
						result_valid <= 1'b1;
						if (kind_q == K_DELETE) begin
							state_q <= S_DEL;
							wait_q <= 1'b1;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DEL: begin
					// Copy store[j] down to store[i]; the read port is registered, so read data lags the address.
					if (j_q >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_IDLE;
					end else if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						cmd <= '{DOP_COPY, 8'(i_q), 8'd0};
						i_q <= i_q + 1'b1;
						j_q <= j_q + 1'b1;
						wait_q <= 1'b1;
					end
				end
				S_INS: begin
					if (i_q == pos_w + 1'b1) begin
						cmd <= '{DOP_WRITE_IN, 8'(i_q), 8'd0};
						count_q <= count_q + 1'b1;
						entry_index <= 4'(i_q);
						entry_key <= in_key;
						entry_grade <= in_grade;
						result_valid <= 1'b1;
						state_q <= S_IDLE;
					end else if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						cmd <= '{DOP_COPY, 8'(i_q), 8'd0};
						i_q <= i_q - 1'b1;
						j_q <= j_q - 1'b1;
						wait_q <= 1'b1;
					end
				end
				S_SORT_RD: begin
					if (j_q >= count_q) begin
						if (i_q + 1'b1 >= count_q) begin
							i_q <= '0;
							n_q <= (count_q > NMAX) ? NMAX : count_q;
							wait_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= i_q + 1'b1;
						end
					end else begin
						state_q <= S_SORT_CMP;
						wait_q <= 1'b1;
					end
				end
				S_SORT_CMP: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						if ($signed(key_a) < $signed(key_b)) begin
							cmd <= '{DOP_SWAP, 8'(i_q), 8'(j_q)};
						end
						j_q <= j_q + 1'b1;
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					// Lets the swap write land before the next read.
					state_q <= S_SORT_RD;
				end
				S_EMIT: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						status <= ST_OK;
						entry_index <= i_q[3:0];
						entry_key <= key_a;
						entry_grade <= grade_a;
						last <= (i_q + 1'b1 == n_q);
						result_valid <= 1'b1;
						i_q <= i_q + 1'b1;
						wait_q <= 1'b1;
						if (i_q + 1'b1 == n_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/static_array_list_engine.sv @@
// Append results and errors found at decode come straight from the decode state;
// read, find, insert and sort walk the store first, and delete stays busy after
// its result while it closes the gap. One command is in flight at a time, and the
// walk over the entries sets the rate. The receiver cannot stall results.
// Reset clears the entry count and sets the append limit to 16; entries undefined.
// ----------------------------------------------------------------------------
// static_array_list_engine
// Fixed-capacity ordered list with append, find, read, delete, insert, sort.
// ----------------------------------------------------------------------------
module static_array_list_engine #(
	parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic signed [31:0] key,
	input  logic [9:0]  grade,
	input  logic [3:0]  position,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	output logic        result_valid,
	output logic [1:0]  status,
	output logic [3:0]  entry_index,
	output logic signed [31:0] entry_key,
	output logic [9:0]  entry_grade,
	output logic        last
);
	import sal_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [4:0] limit_q;
	dp_cmd_t cmd;
	logic [AW-1:0] rd_a, rd_b;
	logic [31:0] in_key, key_a, key_b, ekey;
	logic [9:0] in_grade, grade_a, grade_b;

	assign cfg_ready = 1'b1;
	assign entry_key = $signed(ekey);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	sal_control #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .key(key), .grade(grade), .position(position),
		.limit(limit_q), .cmd(cmd), .rd_a(rd_a), .rd_b(rd_b),
		.in_key(in_key), .in_grade(in_grade),
		.key_a(key_a), .grade_a(grade_a), .key_b(key_b), .grade_b(grade_b),
		.result_valid(result_valid), .status(status), .entry_index(entry_index),
		.entry_key(ekey), .entry_grade(entry_grade), .last(last)
	);

	sal_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .cmd(cmd), .rd_a(rd_a), .rd_b(rd_b),
		.in_key(in_key), .in_grade(in_grade),
		.key_a(key_a), .grade_a(grade_a), .key_b(key_b), .grade_b(grade_b)
	);

endmodule

@@ sim/static_array_list_engine_tb.sv @@
// ----------------------------------------------------------------------------
// static_array_list_engine_tb
// Drives list commands and append-limit writes into the list engine, keeps a
// shadow copy of the list, and compares every result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module static_array_list_engine_tb;
	import sal_pkg::*;

	localparam int CAP = 16;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] index;
		logic [31:0] key;
		logic [9:0] grade;
		logic last;
	} beat_t;

	typedef struct {
		logic [2:0] kind;
		logic [31:0] key;
		logic [9:0] grade;
		logic [3:0] position;
		bit typed;
		logic [1:0] status;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [2:0] kind = 0;
	logic signed [31:0] key = 0;
	logic [9:0] grade = 0;
	logic [3:0] position = 0;
	logic cfg_valid = 0;
	logic [4:0] cfg_data = 0;
	logic busy, cfg_ready, result_valid, last;
	logic [1:0] status;
	logic [3:0] entry_index;
	logic signed [31:0] entry_key;
	logic [9:0] entry_grade;

	logic [31:0] list_keys [CAP];
	logic [9:0] list_grades [CAP];
	int list_len;
	int limit_reg;
	beat_t pending_beats [$];
	int mismatches = 0;
	int idle_pct = 0;
	longint cycles = 0;
	row_t rows [$];

	static_array_list_engine uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.key(key), .grade(grade), .position(position), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data), .result_valid(result_valid),
		.status(status), .entry_index(entry_index), .entry_key(entry_key),
		.entry_grade(entry_grade), .last(last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("static_array_list_engine verification failed");
			$finish;
		end
	end

	function automatic beat_t mk(logic [1:0] s, int i, logic [31:0] k, logic [9:0] g);
		beat_t b;
		b.status = s;
		b.index = i[3:0];
		b.key = k;
		b.grade = g;
		b.last = 1'b1;
		return b;
	endfunction

	task automatic predict_list_op(logic [2:0] op, logic [31:0] k, logic [9:0] g,
			logic [3:0] p);
		int lim;
		int found;
		int n;
		logic [31:0] tk;
		logic [9:0] tg;
		beat_t b;
		if (g > GRADE_MAX)
			g = GRADE_MAX;
		case (op)
			K_APPEND: begin
				lim = (limit_reg > CAP) ? CAP : limit_reg;
				if (list_len >= lim) begin
					pending_beats.push_back(mk(ST_FULL, 0, 0, 0));
				end else begin
					list_keys[list_len] = k;
					list_grades[list_len] = g;
					pending_beats.push_back(mk(ST_OK, list_len, k, g));
					list_len++;
				end
			end
			K_FIND: begin
				if (list_len == 0) begin
					pending_beats.push_back(mk(ST_EMPTY, 0, 0, 0));
				end else begin
					found = -1;
					for (int i = list_len - 1; i >= 0; i--)
						if (list_keys[i] == k)
							found = i;
					if (found < 0)
						pending_beats.push_back(mk(ST_MISS, 0, 0, 0));
					else
						pending_beats.push_back(mk(ST_OK, found, k, list_grades[found]));
				end
			end
			K_READ, K_DELETE: begin
				if (list_len == 0) begin
					pending_beats.push_back(mk(ST_EMPTY, 0, 0, 0));
				end else if (p >= list_len) begin
					pending_beats.push_back(mk(ST_MISS, 0, 0, 0));
				end else begin
					pending_beats.push_back(mk(ST_OK, p, list_keys[p], list_grades[p]));
					if (op == K_DELETE) begin
						for (int i = p; i + 1 < list_len; i++) begin
							list_keys[i] = list_keys[i + 1];
							list_grades[i] = list_grades[i + 1];
						end
						list_len--;
					end
				end
			end
			K_INSERT: begin
				if (list_len == 0) begin
					pending_beats.push_back(mk(ST_EMPTY, 0, 0, 0));
				end else if (list_len >= CAP) begin
					pending_beats.push_back(mk(ST_FULL, 0, 0, 0));
				end else if (p >= list_len) begin
					pending_beats.push_back(mk(ST_MISS, 0, 0, 0));
				end else begin
					for (int i = list_len; i > p + 1; i--) begin
						list_keys[i] = list_keys[i - 1];
						list_grades[i] = list_grades[i - 1];
					end
					list_keys[p + 1] = k;
					list_grades[p + 1] = g;
					list_len++;
					pending_beats.push_back(mk(ST_OK, p + 1, k, g));
				end
			end
			K_SORT: begin
				if (list_len == 0) begin
					pending_beats.push_back(mk(ST_EMPTY, 0, 0, 0));
				end else begin
					for (int i = 0; i < list_len; i++)
						for (int j = i; j < list_len; j++)
							if ($signed(list_keys[i]) < $signed(list_keys[j])) begin
								tk = list_keys[i];
								tg = list_grades[i];
								list_keys[i] = list_keys[j];
								list_grades[i] = list_grades[j];
								list_keys[j] = tk;
								list_grades[j] = tg;
							end
					n = list_len;
					for (int i = 0; i < n; i++) begin
						b = mk(ST_OK, i, list_keys[i], list_grades[i]);
						b.last = (i + 1 == n);
						pending_beats.push_back(b);
					end
				end
			end
			default: pending_beats.push_back(mk(ST_MISS, 0, 0, 0));
		endcase
	endtask

	always @(posedge clk) begin
		beat_t got, want;
		if (arst_n && result_valid) begin
			got = '{status, entry_index, entry_key, entry_grade, last};
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %p", got);
			end else begin
				want = pending_beats.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	task automatic send_cmd(logic [2:0] op, logic [31:0] k, logic [9:0] g, logic [3:0] p);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		kind <= op;
		key <= k;
		grade <= g;
		position <= p;
		do
			@(posedge clk);
		while (busy);
		predict_list_op(op, k, g, p);
	endtask

	task automatic write_limit(int v);
		start <= 1'b0;
		while (pending_beats.size() != 0 || busy)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v[4:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		limit_reg = v;
	endtask

	function automatic row_t r(logic [2:0] op, logic [31:0] k, logic [9:0] g, int p,
			bit t = 0, logic [1:0] s = ST_OK);
		row_t x;
		x = '{op, k, g, p[3:0], t, s};
		return x;
	endfunction

	task automatic random_cmd();
		int sel;
		logic [2:0] op;
		logic [31:0] k;
		sel = $urandom_range(99);
		if (sel < 35)
			op = K_APPEND;
		else if (sel < 50)
			op = K_FIND;
		else if (sel < 62)
			op = K_READ;
		else if (sel < 76)
			op = K_DELETE;
		else if (sel < 90)
			op = K_INSERT;
		else if (sel < 96)
			op = K_SORT;
		else
			op = 3'($urandom_range(7, 6));
		k = $urandom;
		if ($urandom_range(3) == 0 && list_len > 0)
			k = list_keys[$urandom_range(list_len - 1)];
		else if ($urandom_range(3) == 0)
			k = 32'($urandom_range(5));
		send_cmd(op, k, 10'($urandom), 4'($urandom_range(15)));
	endtask

	initial begin
		int lims [4];
		lims = '{1, 0, 31, 7};
		list_len = 0;
		limit_reg = LIMIT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back(r(K_FIND, 5, 0, 0, 1, ST_EMPTY));
		rows.push_back(r(K_READ, 0, 0, 0, 1, ST_EMPTY));
		rows.push_back(r(K_DELETE, 0, 0, 0, 1, ST_EMPTY));
		rows.push_back(r(K_INSERT, 1, 1, 0, 1, ST_EMPTY));
		rows.push_back(r(K_SORT, 0, 0, 0, 1, ST_EMPTY));
		rows.push_back(r(3'd6, 0, 0, 0, 1, ST_MISS));
		rows.push_back(r(3'd7, 0, 0, 0, 1, ST_MISS));
		rows.push_back(r(K_APPEND, 32'h8000_0000, 10'd0, 0));
		rows.push_back(r(K_APPEND, 32'h7fff_ffff, 10'd1023, 0));
		rows.push_back(r(K_APPEND, 32'hffff_ffff, 10'd1000, 0));
		rows.push_back(r(K_INSERT, 32'h0000_0000, 10'd1001, 0));
		rows.push_back(r(K_INSERT, 9, 9, 4));
		rows.push_back(r(K_INSERT, 9, 9, 15, 1, ST_MISS));
		rows.push_back(r(K_READ, 0, 0, 15, 1, ST_MISS));
		rows.push_back(r(K_FIND, 32'h7fff_ffff, 0, 0));
		rows.push_back(r(K_FIND, 12345, 0, 0, 1, ST_MISS));
		rows.push_back(r(K_READ, 0, 0, 2));
		rows.push_back(r(K_SORT, 0, 0, 0));
		rows.push_back(r(K_DELETE, 0, 0, 0));
		rows.push_back(r(K_DELETE, 0, 0, 4));
		rows.push_back(r(K_DELETE, 0, 0, 15, 1, ST_MISS));
		rows.push_back(r(K_READ, 0, 0, 0));
		foreach (rows[i]) begin
			send_cmd(rows[i].kind, rows[i].key, rows[i].grade, rows[i].position);
			if (rows[i].typed && pending_beats[$].status !== rows[i].status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: status table %0d, predictor %0d", i,
						rows[i].status, pending_beats[$].status);
			end
		end
		// Fill to capacity, then probe the full cases.
		while (list_len < CAP)
			send_cmd(K_APPEND, $urandom, 10'($urandom), 0);
		send_cmd(K_APPEND, 1, 1, 0);
		send_cmd(K_INSERT, 1, 1, 0);
		send_cmd(K_SORT, 0, 0, 0);
		send_cmd(K_DELETE, 0, 0, 15);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 24 : (ph == 1) ? 81 : 0;
			for (int l = 0; l < 4; l++) begin
				write_limit((l == 3 && ph == 2) ? 16 : lims[(l + ph) % 4]);
				for (int n = 0; n < 25; n++)
					random_cmd();
			end
		end
		start <= 1'b0;

		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("static_array_list_engine verification clean");
		else
			$display("static_array_list_engine verification failed");
		$finish;
	end

endmodule
